FILE: src/dceb_pkg.sv
// Package for the coincidence event builder: widths, register indexes and the close record.
`timescale 1ns / 1ps
`default_nettype none
package dceb_pkg;
  localparam int TIME_BITS_DEF   = 48;
  localparam int HEIGHT_BITS_DEF = 16;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 16;
  localparam int Q_BITS          = 18;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_KICKER  = 3'd0,
    REG_TIMING  = 3'd1,
    REG_POSMAP  = 3'd2,
    REG_PLOW    = 3'd3,
    REG_PHIGH   = 3'd4,
    REG_WINDOW  = 3'd5
  } reg_idx_t;

  // Record of one closed window handed from the front part to the back part.
  typedef struct packed {
    logic [15:0] pulse_a;
    logic [15:0] pulse_b;
    logic [15:0] pulse_c;
    logic [15:0] pulse_d;
    logic [63:0] group_start;
    logic [63:0] start_since_kick;
    logic [9:0]  hit_total;
    logic [31:0] kick_total;
    logic [31:0] timing_total;
  } close_rec_t;
endpackage
`default_nettype wire

FILE: src/detector_coincidence_event_builder_top.sv
// Top level of the coincidence event builder.
`timescale 1ns / 1ps
`default_nettype none
// Hits enter on the slave stream and pass through the front part in turn
// (capture and classify, then update state); a new hit is taken only after
// the last one is through. A closing hit puts a record into a four-deep queue;
// the back part computes both charge ratios with two bit-serial dividers that
// run side by side, then holds the result word until taken. Hits keep flowing
// while the dividers work, until the queue nears full.
module detector_coincidence_event_builder_top #(
  parameter int TIME_BITS   = dceb_pkg::TIME_BITS_DEF,
  parameter int HEIGHT_BITS = dceb_pkg::HEIGHT_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // channel[3:0], energy, timestamp, zero fill
  input  wire logic [((4+HEIGHT_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pulse_a,b,c,d, group_start, start_since_kick, hit_total, kick_total,
  // timing_total, pos_x, pos_y, zero fill
  output logic [((139+2*TIME_BITS+2*dceb_pkg::Q_BITS+7)/8)*8-1:0] m_axis_tdata
);
  import dceb_pkg::*;
  close_rec_t rec_w, rec_q;
  logic rec_v, full, q_v, q_take;

  dceb_front #(.TIME_BITS(TIME_BITS), .HEIGHT_BITS(HEIGHT_BITS)) u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_channel(s_axis_tdata[3:0]),
    .in_energy(s_axis_tdata[4 +: HEIGHT_BITS]),
    .in_timestamp(s_axis_tdata[4+HEIGHT_BITS +: TIME_BITS]),
    .rec_valid(rec_v), .rec(rec_w), .rec_full(full));

  dceb_queue u_queue (.clk, .rst, .wr_valid(rec_v), .wr_data(rec_w),
    .almost_full(full), .rd_valid(q_v), .rd_take(q_take), .rd_data(rec_q));

  dceb_back #(.TIME_BITS(TIME_BITS)) u_back (.clk, .rst, .rec_valid(q_v),
    .rec_take(q_take), .rec(rec_q), .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready), .out_data(m_axis_tdata));
endmodule
`default_nettype wire

FILE: src/dceb_front.sv
// Front part: classifies hits, keeps counters and anode store, forms close records.
`timescale 1ns / 1ps
`default_nettype none
module dceb_front #(
  parameter int TIME_BITS   = dceb_pkg::TIME_BITS_DEF,
  parameter int HEIGHT_BITS = dceb_pkg::HEIGHT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [15:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [3:0]             in_channel,
  input  wire logic [HEIGHT_BITS-1:0] in_energy,
  input  wire logic [TIME_BITS-1:0]   in_timestamp,
  output logic                        rec_valid,
  output dceb_pkg::close_rec_t        rec,
  input  wire logic                   rec_full
);
  import dceb_pkg::*;

  logic [3:0]  kicker_channel, timing_channel;
  logic [15:0] position_channel_map, pulse_low, pulse_high, coincidence_window;
  logic [31:0] kick_count, timing_count;
  logic [TIME_BITS-1:0] kick_time, window_start;
  logic kick_pending, timing_pending;
  logic [15:0] anode_height [4];
  logic [7:0]  anode_hits [4];

  // Stage-1 registers: hit captured and classified.
  logic                   s1_valid;
  logic [3:0]             s1_ch;
  logic [HEIGHT_BITS-1:0] s1_e;
  logic [TIME_BITS-1:0]   s1_t;
  logic                   s1_kick, s1_tim;
  logic [TIME_BITS:0]     s1_diff;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid && !rec_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kicker_channel       <= 4'd0;
      timing_channel       <= 4'd1;
      position_channel_map <= 16'h7654;
      pulse_low            <= 16'd0;
      pulse_high           <= 16'hFFFF;
      coincidence_window   <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KICKER: kicker_channel       <= cfg_data[3:0];
        REG_TIMING: timing_channel       <= cfg_data[3:0];
        REG_POSMAP: position_channel_map <= cfg_data;
        REG_PLOW:   pulse_low            <= cfg_data;
        REG_PHIGH:  pulse_high           <= cfg_data;
        REG_WINDOW: coincidence_window   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic in_win;
  logic [16:0] e_ext;
  assign e_ext  = {{(17-HEIGHT_BITS){1'b0}}, in_energy};
  assign in_win = (e_ext > {1'b0, pulse_low}) && (e_ext < {1'b0, pulse_high});

  // Stage 2 decisions from registered hit.
  logic kick_pend_n, tim_pend_n, do_close;
  logic [31:0] kc_n, tc_n;
  logic [TIME_BITS-1:0] kt_n;
  logic [TIME_BITS:0] wdiff;
  logic [2:0] slot;
  logic [9:0] tot;
  logic [TIME_BITS:0] ssk;

  always_comb begin
    kc_n = kick_count;
    tc_n = timing_count;
    kt_n = kick_time;
    kick_pend_n = kick_pending;
    tim_pend_n  = timing_pending;
    if (s1_kick) begin
      if (kick_count != '1) kc_n = kick_count + 32'd1;
      kt_n = s1_t;
      kick_pend_n = 1'b1;
    end else if (s1_tim) begin
      if (timing_count != '1) tc_n = timing_count + 32'd1;
      tim_pend_n = 1'b1;
    end
    wdiff = s1_diff;
    do_close = (kc_n != 32'd0) && ((!wdiff[TIME_BITS] &&
               (wdiff > {{(TIME_BITS-15){1'b0}}, coincidence_window}))
               || kick_pend_n || tim_pend_n);
    slot = 3'd4;
    for (int k = 3; k >= 0; k--) begin
      if (s1_ch == position_channel_map[4*k +: 4]) slot = 3'(k);
    end
    tot = 10'(anode_hits[0]) + 10'(anode_hits[1]) + 10'(anode_hits[2])
        + 10'(anode_hits[3]);
    ssk = {1'b0, window_start} - {1'b0, kt_n};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      rec_valid <= 1'b0;
      kick_count <= '0;
      timing_count <= '0;
      kick_time <= '0;
      window_start <= '0;
      kick_pending <= 1'b0;
      timing_pending <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        anode_height[k] <= '0;
        anode_hits[k]   <= '0;
      end
    end else begin
      rec_valid <= s1_valid && do_close;
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
        s1_ch    <= in_channel;
        s1_e     <= in_energy;
        s1_t     <= in_timestamp;
        s1_kick  <= (in_channel == kicker_channel) && in_win;
        s1_tim   <= (in_channel == timing_channel) && in_win;
        s1_diff  <= {1'b0, in_timestamp} - {1'b0, window_start};
      end else if (s1_valid) begin
        s1_valid     <= 1'b0;
        kick_count   <= kc_n;
        timing_count <= tc_n;
        kick_time    <= kt_n;
        kick_pending   <= kick_pend_n && !do_close;
        timing_pending <= tim_pend_n && !do_close;
        if (do_close) begin
          rec.pulse_a <= anode_height[0];
          rec.pulse_b <= anode_height[1];
          rec.pulse_c <= anode_height[2];
          rec.pulse_d <= anode_height[3];
          rec.group_start <= 64'(window_start);
          rec.start_since_kick <= 64'(ssk);
          rec.hit_total <= tot;
          rec.kick_total <= kc_n;
          rec.timing_total <= tc_n;
          window_start <= s1_t;
        end
        for (int k = 0; k < 4; k++) begin
          if (slot == 3'(k)) begin
            anode_height[k] <= 16'(s1_e);
            if (do_close) anode_hits[k] <= 8'd1;
            else if (anode_hits[k] != 8'hFF) anode_hits[k] <= anode_hits[k] + 8'd1;
          end else if (do_close) begin
            anode_height[k] <= '0;
            anode_hits[k]   <= '0;
          end
        end
      end
    end
  end

  // A close record is only formed in the cycle after a classified hit.
  a_rec_after_hit: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> $past(s1_valid)) else $error("record without hit");
  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> !s1_valid) else $error("hit held twice");
  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    rec_full |-> !in_ready) else $error("accept while queue full");
endmodule
`default_nettype wire

FILE: src/dceb_queue.sv
// Short FIFO of close records between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module dceb_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_valid,
  input  wire dceb_pkg::close_rec_t wr_data,
  output logic                      almost_full,
  output logic                      rd_valid,
  input  wire logic                 rd_take,
  output dceb_pkg::close_rec_t      rd_data
);
  import dceb_pkg::*;
  localparam int DEPTH = 4;
  close_rec_t mem [DEPTH];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  // Front stops taking hits while a record could still arrive with the queue near full.
  assign almost_full = (cnt >= 3'(DEPTH - 1));
  assign rd_valid = (cnt != 3'd0);
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr_valid) wp <= wp + 2'd1;
      if (rd_take && rd_valid) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr_valid) - 3'(rd_take && rd_valid);
    end
  end
endmodule
`default_nettype wire

FILE: src/dceb_back.sv
// Back part: radix-2 restoring division for both charge ratios, then output register.
`timescale 1ns / 1ps
`default_nettype none
module dceb_back #(
  parameter int TIME_BITS = dceb_pkg::TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rec_valid,
  output logic                      rec_take,
  input  wire dceb_pkg::close_rec_t rec,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [((139+2*TIME_BITS+2*dceb_pkg::Q_BITS+7)/8)*8-1:0] out_data
);
  import dceb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_DIV = 3'b010, S_OUT = 3'b100
  } state_t;
  state_t state;

  close_rec_t cur;
  logic [4:0]  step;
  logic [32:0] rx, ry;
  logic [32:0] qx, qy;
  logic [16:0] dx, dy;

  logic [33:0] tx, ty;
  assign tx = {rx[32:0], qx[32]} - {17'd0, dx};
  assign ty = {ry[32:0], qy[32]} - {17'd0, dy};

  assign rec_take  = (state == S_IDLE) && rec_valid;
  assign out_valid = (state == S_OUT);

  logic [Q_BITS-1:0] px, py;
  assign px = (dx == 17'd0) ? '1 : qx[Q_BITS-1:0];
  assign py = (dy == 17'd0) ? '1 : qy[Q_BITS-1:0];

  always_comb begin
    out_data = '0;
    out_data[15:0]   = cur.pulse_a;
    out_data[31:16]  = cur.pulse_b;
    out_data[47:32]  = cur.pulse_c;
    out_data[63:48]  = cur.pulse_d;
    out_data[64 +: TIME_BITS] = cur.group_start[TIME_BITS-1:0];
    out_data[64+TIME_BITS +: TIME_BITS+1] = cur.start_since_kick[TIME_BITS:0];
    out_data[65+2*TIME_BITS +: 10]  = cur.hit_total;
    out_data[75+2*TIME_BITS +: 32]  = cur.kick_total;
    out_data[107+2*TIME_BITS +: 32] = cur.timing_total;
    out_data[139+2*TIME_BITS +: Q_BITS] = px;
    out_data[157+2*TIME_BITS +: Q_BITS] = py;
  end

  // One quotient bit per cycle for each ratio; the 32-bit dividend A<<16 sits in the
  // top of the shift register, so once all of it has shifted through, the quotient is in its low bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (rec_valid) begin
          cur  <= rec;
          qx   <= {rec.pulse_a, 16'd0, 1'b0};
          qy   <= {rec.pulse_c, 16'd0, 1'b0};
          rx   <= '0; ry <= '0;
          dx   <= 17'(rec.pulse_a) + 17'(rec.pulse_b);
          dy   <= 17'(rec.pulse_c) + 17'(rec.pulse_d);
          step <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!tx[33]) begin rx <= tx[32:0]; qx <= {qx[31:0], 1'b1}; end
          else begin rx <= {rx[31:0], qx[32]}; qx <= {qx[31:0], 1'b0}; end
          if (!ty[33]) begin ry <= ty[32:0]; qy <= {qy[31:0], 1'b1}; end
          else begin ry <= {ry[31:0], qy[32]}; qy <= {qy[31:0], 1'b0}; end
          step <= step + 5'd1;
          if (step == 5'd31) state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("word dropped");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    rec_take |=> state == S_DIV) else $error("take outside idle");
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state code");
endmodule
`default_nettype wire

FILE: dv/detector_coincidence_event_builder_top_tb.sv
// Self-checking testbench for the coincidence event builder: directed hits, then random phases.
`timescale 1ns / 1ps
module detector_coincidence_event_builder_top_tb;
  import dceb_pkg::*;

  localparam int IN_W  = ((4 + 16 + 48 + 7) / 8) * 8;
  localparam int LIMIT = 600000;
  localparam int NFLD  = 11;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

  // Offsets and widths of the result fields in the packed result word.
  localparam int FOFF[NFLD] = '{0, 16, 32, 48, 64, 112, 161, 171, 203, 235, 253};
  localparam int FWID[NFLD] = '{16, 16, 16, 16, 48, 49, 10, 32, 32, 18, 18};
  localparam string FNAME[NFLD] = '{"pulse_a", "pulse_b", "pulse_c", "pulse_d",
    "group_start", "start_since_kick", "hit_total", "kick_total", "timing_total",
    "pos_x", "pos_y"};

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [2:0]      cfg_index = '0;
  logic [15:0]     cfg_data = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [271:0]    m_axis_tdata;

  detector_coincidence_event_builder_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration and the event state.
  logic [3:0]  kick_ch, timing_ch;
  logic [15:0] anode_map, height_low, height_high, win_len;
  logic [31:0] kicks, timings;
  logic [47:0] kick_at, win_start;
  logic        kick_flag, timing_flag;
  logic [15:0] anode_e[4];
  logic [7:0]  anode_n[4];

  logic [271:0] event_queue[$];
  int           errors = 0;
  int           cycles = 0;
  int           stall_left = 0;
  bit           stall_off = 0;

  function automatic logic [17:0] charge_ratio(logic [15:0] num, logic [15:0] other);
    logic [16:0] den;
    logic [32:0] q;
    den = {1'b0, num} + {1'b0, other};
    if (den == 0) return '1;
    q = ({17'b0, num} << 16) / den;
    return q[17:0];
  endfunction

  function automatic logic [271:0] pack_event(logic [15:0] a, logic [15:0] b, logic [15:0] c,
      logic [15:0] d, logic [47:0] gs, logic [48:0] since, logic [9:0] hits, logic [31:0] kt,
      logic [31:0] tt, logic [17:0] px, logic [17:0] py);
    return {1'b0, py, px, tt, kt, hits, since, gs, d, c, b, a};
  endfunction

  task automatic reset_shadow();
    kick_ch = 4'd0; timing_ch = 4'd1; anode_map = 16'h7654;
    height_low = 16'd0; height_high = 16'hFFFF; win_len = 16'd1;
    kicks = '0; timings = '0; kick_at = '0; win_start = '0;
    kick_flag = 0; timing_flag = 0;
    for (int k = 0; k < 4; k++) begin
      anode_e[k] = '0;
      anode_n[k] = '0;
    end
  endtask

  // Advances the shadow state by one hit; returns 1 with the closed event if a window closes.
  function automatic bit build_event(logic [3:0] ch, logic [15:0] e, logic [47:0] t,
      output logic [271:0] ev);
    bit   trig;
    bit   closed;
    int   slot;
    longint diff;
    logic [9:0] total;
    trig = (e > height_low) && (e < height_high);
    closed = 0;
    ev = '0;
    if (ch == kick_ch && trig) begin
      if (kicks != '1) kicks++;
      kick_at = t;
      kick_flag = 1;
    end else if (ch == timing_ch && trig) begin
      if (timings != '1) timings++;
      timing_flag = 1;
    end
    if (kicks != 0) begin
      diff = longint'({16'b0, t}) - longint'({16'b0, win_start});
      if (diff > longint'(win_len) || kick_flag || timing_flag) begin
        total = 10'(anode_n[0]) + 10'(anode_n[1]) + 10'(anode_n[2]) + 10'(anode_n[3]);
        ev = pack_event(anode_e[0], anode_e[1], anode_e[2], anode_e[3], win_start,
                        {1'b0, win_start} - {1'b0, kick_at}, total, kicks, timings,
                        charge_ratio(anode_e[0], anode_e[1]),
                        charge_ratio(anode_e[2], anode_e[3]));
        closed = 1;
        kick_flag = 0;
        timing_flag = 0;
        for (int k = 0; k < 4; k++) begin
          anode_e[k] = '0;
          anode_n[k] = '0;
        end
        win_start = t;
      end
    end
    slot = -1;
    for (int k = 3; k >= 0; k--)
      if (ch == anode_map[4*k +: 4]) slot = k;
    if (slot >= 0) begin
      if (anode_n[slot] != 8'hFF) anode_n[slot]++;
      anode_e[slot] = e;
    end
    return closed;
  endfunction

  // Random gap before a word: mostly none or short, now and then long.
  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
        ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sends one hit and queues the event it closes, if any; typed_ev is checked when has_typed.
  task automatic send_hit(logic [3:0] ch, logic [15:0] e, logic [47:0] t,
      bit has_typed = 0, logic [271:0] typed_ev = '0);
    logic [271:0] ev;
    bit closed;
    sender_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, t, e, ch};
    do @(posedge clk); while (!s_axis_tready);
    closed = build_event(ch, e, t, ev);
    if (has_typed && (!closed || ev != typed_ev)) begin
      errors++;
      $display("Hand-worked event differs from prediction for hit ch %0d at %0d", ch, t);
    end
    if (closed) event_queue.push_back(ev);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_KICKER: kick_ch     = value[3:0];
      REG_TIMING: timing_ch   = value[3:0];
      REG_POSMAP: anode_map   = value;
      REG_PLOW:   height_low  = value;
      REG_PHIGH:  height_high = value;
      REG_WINDOW: win_len     = value;
      default: ;
    endcase
  endtask

  // Holds the sender until every event is out and the front part has settled.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (event_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Result side: random stalls, with some stretches that never stall.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!stall_off && $urandom_range(0, 4) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
    end
  end

  // Compares each accepted result word with the oldest predicted event.
  always @(posedge clk) begin
    logic [271:0] want;
    logic [271:0] got;
    bit bad;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (event_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result word %h", m_axis_tdata);
      end else begin
        want = event_queue.pop_front();
        got  = m_axis_tdata;
        for (int f = 0; f < NFLD; f++) begin
          bad = 0;
          for (int b = 0; b < FWID[f]; b++)
            if (want[FOFF[f] + b] !== got[FOFF[f] + b]) bad = 1;
          if (bad) begin
            errors++;
            if (errors <= 10)
              $display("Field %s: expected %h, got %h", FNAME[f],
                       (want >> FOFF[f]) & ((272'd1 << FWID[f]) - 1),
                       (got >> FOFF[f]) & ((272'd1 << FWID[f]) - 1));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  typedef struct {
    logic [3:0]   ch;
    logic [15:0]  e;
    logic [47:0]  t;
    bit           typed;
    logic [271:0] ev;
  } hit_row_t;

  hit_row_t directed[$];

  task automatic random_phase(int items);
    logic [47:0] now;
    logic [15:0] e;
    logic [3:0]  ch;
    int pick;
    now = 48'({$urandom, $urandom}) & TMAX;
    if ($urandom_range(0, 1)) now = now >> $urandom_range(0, 47);
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      e = 16'($urandom);
      if (pick < 10) begin
        // Noise: any channel, height and time at all.
        ch = 4'($urandom);
        now = 48'({$urandom, $urandom}) & TMAX;
      end else begin
        now = now + 48'($urandom_range(0, 2 * win_len + 2));
        if (pick < 18) ch = kick_ch;
        else if (pick < 25) ch = timing_ch;
        else ch = anode_map[4 * $urandom_range(0, 3) +: 4];
        if (pick < 25 && height_high > height_low + 1)
          e = 16'($urandom_range(height_low + 1, height_high - 1));
      end
      send_hit(ch, e, now);
    end
  endtask

  initial begin
    logic [15:0] lo;
    reset_shadow();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed hits under reset settings; events worked by hand where simple.
    directed.push_back('{4'd4, 16'd100,   48'd5,  0, '0});
    directed.push_back('{4'd5, 16'd0,     48'd6,  0, '0});
    directed.push_back('{4'd0, 16'd0,     48'd7,  0, '0});
    directed.push_back('{4'd0, 16'hFFFF,  48'd8,  0, '0});
    directed.push_back('{4'd0, 16'd1,     48'd20, 1,
      pack_event(16'd100, 0, 0, 0, 48'd0, 49'h1_FFFF_FFFF_FFEC, 10'd2, 32'd1, 32'd0,
                 18'd65536, '1)});
    directed.push_back('{4'd1, 16'hFFFE,  48'd21, 1,
      pack_event(0, 0, 0, 0, 48'd20, 49'd0, 10'd0, 32'd1, 32'd1, '1, '1)});
    directed.push_back('{4'd6, 16'd7,     48'd21, 0, '0});
    directed.push_back('{4'd7, 16'd9,     48'd22, 0, '0});
    directed.push_back('{4'd6, 16'd3,     48'd23, 1,
      pack_event(0, 0, 16'd7, 16'd9, 48'd21, 49'd1, 10'd2, 32'd1, 32'd1, '1, 18'd28672)});
    directed.push_back('{4'd4, 16'hFFFF,  48'd0,  0, '0});
    directed.push_back('{4'd5, 16'hFFFF,  TMAX,   0, '0});
    directed.push_back('{4'd0, 16'd2,     TMAX,   0, '0});
    directed.push_back('{4'd15, 16'h5555, 48'hAAAA_AAAA_AAAA, 0, '0});
    directed.push_back('{4'd1, 16'hAAAA,  48'h5555_5555_5555, 0, '0});
    directed.push_back('{4'd7, 16'h8000,  48'h5555_5555_5556, 0, '0});
    foreach (directed[i])
      send_hit(directed[i].ch, directed[i].e, directed[i].t, directed[i].typed, directed[i].ev);

    // Random phases, each under fresh settings; the extremes come first.
    for (int p = 0; p < 9; p++) begin
      drain();
      stall_off = (p % 3 == 2);
      write_reg(REG_KICKER, 16'($urandom));
      write_reg(REG_TIMING, (p == 3) ? {12'b0, kick_ch} : 16'($urandom));
      write_reg(REG_POSMAP, (p == 4) ? {kick_ch, kick_ch, timing_ch, kick_ch} :
                             (p == 0) ? 16'h7654 : 16'($urandom));
      lo = (p == 1) ? 16'hFFFF : (p < 3) ? 16'd0 : 16'($urandom_range(0, 30000));
      write_reg(REG_PLOW, lo);
      write_reg(REG_PHIGH, (p == 1) ? 16'd0 : (p < 3) ? 16'hFFFF :
                           16'($urandom_range(30000, 65535)));
      write_reg(REG_WINDOW, (p == 0) ? 16'd0 : (p == 2) ? 16'hFFFF :
                            16'($urandom_range(0, 40)));
      random_phase(60);
    end

    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/dceb_pkg.sv
src/dceb_front.sv
src/dceb_queue.sv
src/dceb_back.sv
src/detector_coincidence_event_builder_top.sv
dv/detector_coincidence_event_builder_top_tb.sv
